// ===== hdl/wps_pkg.sv =====
// Shared types, constants and helpers for the weighted processor-sharing table.
package wps_pkg;

  localparam int TIME_W = 48;
  localparam int HALF_W = TIME_W / 2;
  localparam int WEIGHT_W = 16;
  localparam int CLASS_W = 2;
  localparam int TAG_W = 8;
  localparam int OCC_W = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int NUM_WREG = 4;

  localparam int MAX_JOBS_DEF = 16;
  localparam int NUM_CLASSES_DEF = 4;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;
  localparam logic [WEIGHT_W-1:0] ONE_WEIGHT = 16'd256;
  localparam logic [WEIGHT_W-1:0] MIN_WEIGHT = 16'd1;
  localparam logic [OCC_W-1:0] CAP_RESET = 5'd16;

  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd4;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_DEPART = 1'b1;

  typedef struct packed {
    logic                operation;
    logic [TIME_W-1:0]   now_time;
    logic [CLASS_W-1:0]  job_class;
    logic [TAG_W-1:0]    job_tag;
    logic [TIME_W-1:0]   alone_finish;
  } job_t;

  typedef struct packed {
    logic                accepted;
    logic [TAG_W-1:0]    out_tag;
    logic [CLASS_W-1:0]  out_class;
    logic [TIME_W-1:0]   out_finish;
    logic [OCC_W-1:0]    occupancy;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] t;
  } sc_req_t;

  typedef struct packed {
    logic              done;
    logic [TIME_W-1:0] result;
  } sc_rsp_t;

  typedef enum logic [2:0] {
    SC_IDLE,
    SC_MUL_LO,
    SC_MUL_HI,
    SC_CHECK,
    SC_DIV,
    SC_FINISH
  } sc_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_RS_READ,
    ST_RS_GO,
    ST_RS_WAIT,
    ST_NEW_GO,
    ST_NEW_WAIT
  } wps_state_t;

  function automatic logic [WEIGHT_W-1:0] class_weight(
    input logic [CLASS_W-1:0] cls,
    input logic [NUM_WREG-1:0][WEIGHT_W-1:0] regs,
    input int ncls
  );
    logic [WEIGHT_W-1:0] w;
    w = regs[cls];
    if (int'(cls) >= ncls) return ONE_WEIGHT;
    if (w == '0) return MIN_WEIGHT;
    return w;
  endfunction

endpackage

// ===== hdl/weighted_processor_sharing_top.sv =====
// Top level of the weighted processor-sharing service table.
//
// Usage: drive job with start while busy is low; the transaction is taken at that
// edge and busy rises. A job carries an arrival (store a job) or a departure (remove
// the job with the earliest finish). When the work is done, done pulses for one
// cycle with the result; busy is low in that same cycle and a new start is taken.
// The receiver cannot stall; result holds until the next transaction rewrites it.
// Sequence: a sweep over the slot memory, one decision step, then one shared
// multiply/divide unit per rescaled slot (read, launch, two partial products, a
// range check, a bit-serial restoring divide over the 48-bit time, a finish, the
// strobe); the divide is skipped when the quotient saturates, and each empty slot
// visited takes a read step. An arrival then also scales the new job. Refused
// transactions finish after the sweep.
// Configuration: cfg_we writes register cfg_index with cfg_data; the user must
// do so only while idle, as the block itself does not enforce it.
// Reset: synchronous rst empties the table, sets every weight to 1.0 and the
// capacity to 16; no clearing pass is needed.
module weighted_processor_sharing_top #(
  parameter int MAX_JOBS = wps_pkg::MAX_JOBS_DEF,
  parameter int NUM_CLASSES = wps_pkg::NUM_CLASSES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  wps_pkg::job_t                    job,
  output logic                             done,
  output wps_pkg::result_t                 result,
  input  logic                             cfg_we,
  input  logic [wps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wps_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wps_pkg::*;

  localparam int IW = $clog2(MAX_JOBS);
  localparam int SW = IW + 1;
  localparam int OW = $clog2(MAX_JOBS + 1);
  localparam int WW = WEIGHT_W + OW;

  wps_state_t state, state_next;

  logic [NUM_WREG-1:0][WEIGHT_W-1:0] wreg;
  logic [OCC_W-1:0]    cap_reg;

  job_t                job_r;
  logic [SW-1:0]       sidx;
  logic                p_vld;
  logic [IW-1:0]       p_idx;
  logic [IW-1:0]       ridx;
  logic [OW-1:0]       occ;
  logic [MAX_JOBS-1:0] valid;
  logic [WW-1:0]       w_old;
  logic [WW-1:0]       w_new;
  logic [WW-1:0]       wj;
  logic                found;
  logic                free_found;
  logic [IW-1:0]       pick;
  logic [IW-1:0]       free_idx;
  logic [TIME_W-1:0]   min_fin;
  logic [CLASS_W-1:0]  pick_cls;
  logic [TAG_W-1:0]    pick_tag;

  logic [TIME_W-1:0]   fin_mem [MAX_JOBS];
  logic [CLASS_W-1:0]  cls_mem [MAX_JOBS];
  logic [TAG_W-1:0]    tag_mem [MAX_JOBS];
  logic [TIME_W-1:0]   rd_fin;
  logic [CLASS_W-1:0]  rd_cls;
  logic [TAG_W-1:0]    rd_tag;
  logic [IW-1:0]       rd_addr;
  logic                wr_en;
  logic                wr_new;
  logic [IW-1:0]       wr_addr;

  sc_req_t             sc_req;
  sc_rsp_t             sc_rsp;
  logic [WW-1:0]       sc_den;

  logic                full;
  logic                last;
  logic                is_arrive;
  logic [WW-1:0]       wj_job;
  logic [WW-1:0]       wj_pick;
  logic [WW-1:0]       wnew_dep;
  logic [WW-1:0]       wt_rd;

  assign busy = (state != ST_IDLE);
  assign is_arrive = (job_r.operation == OP_ARRIVE);
  assign full = (32'(occ) >= 32'(cap_reg)) || (32'(occ) >= MAX_JOBS);
  assign last = (ridx == IW'(MAX_JOBS - 1));
  assign wj_job = WW'(class_weight(job_r.job_class, wreg, NUM_CLASSES));
  assign wj_pick = WW'(class_weight(pick_cls, wreg, NUM_CLASSES));
  assign wt_rd = WW'(class_weight(rd_cls, wreg, NUM_CLASSES));
  assign wnew_dep = w_old - wj_pick;

  assign sc_den = (state == ST_NEW_GO) ? wj : w_old;

  wps_scale #(
    .WW(WW)
  ) u_scale (
    .clk(clk),
    .rst(rst),
    .req(sc_req),
    .num(w_new),
    .den(sc_den),
    .rsp(sc_rsp)
  );

  always_comb begin
    state_next = state;
    rd_addr = ridx;
    wr_en = 1'b0;
    wr_new = 1'b0;
    wr_addr = ridx;
    sc_req.start = 1'b0;
    sc_req.now = job_r.now_time;
    sc_req.t = (state == ST_NEW_GO) ? job_r.alone_finish : rd_fin;
    case (state)
      ST_IDLE: if (start) state_next = ST_SCAN;
      ST_SCAN: begin
        rd_addr = sidx[IW-1:0];
        if (sidx == SW'(MAX_JOBS) && !p_vld) state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (is_arrive) begin
          if (full) state_next = ST_IDLE;
          else if (w_old != '0) state_next = ST_RS_READ;
          else state_next = ST_NEW_GO;
        end else begin
          if (occ == '0) state_next = ST_IDLE;
          else if (occ > OW'(1) && wnew_dep != '0) state_next = ST_RS_READ;
          else state_next = ST_IDLE;
        end
      end
      ST_RS_READ: begin
        if (valid[ridx]) state_next = ST_RS_GO;
        else if (last) state_next = is_arrive ? ST_NEW_GO : ST_IDLE;
      end
      ST_RS_GO: begin
        sc_req.start = 1'b1;
        state_next = ST_RS_WAIT;
      end
      ST_RS_WAIT: begin
        if (sc_rsp.done) begin
          wr_en = 1'b1;
          if (last) state_next = is_arrive ? ST_NEW_GO : ST_IDLE;
          else state_next = ST_RS_READ;
        end
      end
      ST_NEW_GO: begin
        sc_req.start = 1'b1;
        state_next = ST_NEW_WAIT;
      end
      ST_NEW_WAIT: begin
        wr_addr = free_idx;
        if (sc_rsp.done) begin
          wr_en = 1'b1;
          wr_new = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wreg <= {NUM_WREG{ONE_WEIGHT}};
      cap_reg <= CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WEIGHT0:  wreg[0] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT1:  wreg[1] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT2:  wreg[2] <= cfg_data[WEIGHT_W-1:0];
        REG_WEIGHT3:  wreg[3] <= cfg_data[WEIGHT_W-1:0];
        REG_CAPACITY: cap_reg <= cfg_data[OCC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) fin_mem[wr_addr] <= sc_rsp.result;
    if (wr_new) begin
      cls_mem[wr_addr] <= job_r.job_class;
      tag_mem[wr_addr] <= job_r.job_tag;
    end
    rd_fin <= fin_mem[rd_addr];
    rd_cls <= cls_mem[rd_addr];
    rd_tag <= tag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ <= '0;
      done <= 1'b0;
      p_vld <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (start) begin
            job_r <= job;
            sidx <= '0;
            p_vld <= 1'b0;
            w_old <= '0;
            found <= 1'b0;
            free_found <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (sidx != SW'(MAX_JOBS)) begin
            p_vld <= 1'b1;
            p_idx <= sidx[IW-1:0];
            sidx <= sidx + 1'b1;
          end else begin
            p_vld <= 1'b0;
          end
          if (p_vld) begin
            if (valid[p_idx]) begin
              w_old <= w_old + wt_rd;
              if (!found || rd_fin < min_fin) begin
                found <= 1'b1;
                pick <= p_idx;
                min_fin <= rd_fin;
                pick_cls <= rd_cls;
                pick_tag <= rd_tag;
              end
            end else if (!free_found) begin
              free_found <= 1'b1;
              free_idx <= p_idx;
            end
          end
        end
        ST_DECIDE: begin
          ridx <= '0;
          if (is_arrive) begin
            wj <= wj_job;
            w_new <= w_old + wj_job;
            if (full) begin
              result <= '{accepted: 1'b0, out_tag: job_r.job_tag,
                          out_class: job_r.job_class, out_finish: '0,
                          occupancy: OCC_W'(occ)};
              done <= 1'b1;
            end
          end else if (occ == '0) begin
            result <= '0;
            done <= 1'b1;
          end else begin
            w_new <= wnew_dep;
            valid[pick] <= 1'b0;
            occ <= occ - 1'b1;
            result <= '{accepted: 1'b1, out_tag: pick_tag, out_class: pick_cls,
                        out_finish: min_fin, occupancy: OCC_W'(occ - 1'b1)};
            if (!(occ > OW'(1) && wnew_dep != '0)) done <= 1'b1;
          end
        end
        ST_RS_READ: begin
          if (!valid[ridx]) begin
            if (!last) ridx <= ridx + 1'b1;
            else if (!is_arrive) done <= 1'b1;
          end
        end
        ST_RS_WAIT: begin
          if (sc_rsp.done) begin
            if (!last) ridx <= ridx + 1'b1;
            else if (!is_arrive) done <= 1'b1;
          end
        end
        ST_NEW_WAIT: begin
          if (sc_rsp.done) begin
            valid[free_idx] <= 1'b1;
            occ <= occ + 1'b1;
            result <= '{accepted: 1'b1, out_tag: job_r.job_tag,
                        out_class: job_r.job_class, out_finish: sc_rsp.result,
                        occupancy: OCC_W'(occ + 1'b1)};
            done <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    32'(occ) <= MAX_JOBS)
    else $error("occupancy beyond table size");

  a_occ_count: assert property (@(posedge clk) disable iff (rst)
    !busy |-> 32'($countones(valid)) == 32'(occ))
    else $error("occupancy disagrees with valid slots");

  a_scale_owner: assert property (@(posedge clk) disable iff (rst)
    sc_rsp.done |-> (state == ST_RS_WAIT || state == ST_NEW_WAIT))
    else $error("rescale finished outside a wait state");

endmodule

// ===== hdl/wps_scale.sv =====
// Iterative rescale unit: now +/- floor(|t - now| * num / den), saturated to the time range.
module wps_scale #(
  parameter int WW = 21
) (
  input  logic             clk,
  input  logic             rst,
  input  wps_pkg::sc_req_t req,
  input  logic [WW-1:0]    num,
  input  logic [WW-1:0]    den,
  output wps_pkg::sc_rsp_t rsp
);
  import wps_pkg::*;

  localparam int PW = TIME_W + WW;
  localparam int CNT_W = $clog2(TIME_W);

  sc_state_t state, state_next;

  logic                neg;
  logic [TIME_W-1:0]   mag;
  logic [TIME_W-1:0]   nowr;
  logic [WW-1:0]       numr;
  logic [WW-1:0]       denr;
  logic [PW-1:0]       prod;
  logic [TIME_W-1:0]   low;
  logic [WW-1:0]       rem;
  logic [TIME_W-1:0]   quo;
  logic [CNT_W-1:0]    cnt;

  logic [HALF_W-1:0]    mhalf;
  logic [HALF_W+WW-1:0] pp;
  logic [WW:0]          trial;
  logic                 ge;
  logic [WW-1:0]        rem_next;
  logic [TIME_W:0]      sum;
  logic [TIME_W-1:0]    fin_val;

  assign mhalf = (state == SC_MUL_LO) ? mag[HALF_W-1:0] : mag[TIME_W-1:HALF_W];
  assign pp = (HALF_W+WW)'(mhalf) * (HALF_W+WW)'(numr);
  assign trial = {rem, low[TIME_W-1]};
  assign ge = (trial >= {1'b0, denr});
  assign rem_next = ge ? WW'(trial - {1'b0, denr}) : trial[WW-1:0];
  assign sum = {1'b0, nowr} + {1'b0, quo};

  always_comb begin
    if (neg) begin
      fin_val = (quo > nowr) ? '0 : nowr - quo;
    end else begin
      fin_val = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      SC_IDLE:   if (req.start) state_next = SC_MUL_LO;
      SC_MUL_LO: state_next = SC_MUL_HI;
      SC_MUL_HI: state_next = SC_CHECK;
      SC_CHECK: begin
        if (prod[PW-1:TIME_W] >= denr) state_next = SC_FINISH;
        else state_next = SC_DIV;
      end
      SC_DIV:    if (cnt == CNT_W'(TIME_W-1)) state_next = SC_FINISH;
      SC_FINISH: state_next = SC_IDLE;
      default:   state_next = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SC_IDLE;
      rsp.done <= 1'b0;
    end else begin
      state <= state_next;
      rsp.done <= (state == SC_FINISH);
      if (state == SC_FINISH) rsp.result <= fin_val;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      SC_IDLE: begin
        if (req.start) begin
          neg <= (req.t < req.now);
          mag <= (req.t < req.now) ? req.now - req.t : req.t - req.now;
          nowr <= req.now;
          numr <= num;
          denr <= den;
        end
      end
      SC_MUL_LO: prod <= PW'(pp);
      SC_MUL_HI: prod <= prod + (PW'(pp) << HALF_W);
      SC_CHECK: begin
        quo <= TIME_MAX;
        rem <= prod[PW-1:TIME_W];
        low <= prod[TIME_W-1:0];
        cnt <= '0;
      end
      SC_DIV: begin
        quo <= {quo[TIME_W-2:0], ge};
        low <= low << 1;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the weighted processor-sharing service table.
`timescale 1ns / 100ps

module tb;
  import wps_pkg::*;

  localparam int SLOTS = 16;
  localparam int NCLS = 4;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  job_t job;
  logic done;
  result_t result;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  weighted_processor_sharing_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .job(job),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [WEIGHT_W-1:0] shadow_weight [NUM_WREG];
  logic [OCC_W-1:0] shadow_cap;
  logic slot_busy [SLOTS];
  logic [TIME_W-1:0] slot_fin [SLOTS];
  logic [CLASS_W-1:0] slot_cls [SLOTS];
  logic [TAG_W-1:0] slot_id [SLOTS];

  job_t pending_jobs[$];
  result_t expected_results[$];
  int gap_left;
  int mismatches;
  bit quiet;
  logic [TIME_W-1:0] sim_now;

  function automatic logic [23:0] share_of(logic [CLASS_W-1:0] cls);
    if (int'(cls) >= NCLS) return 24'(ONE_WEIGHT);
    if (shadow_weight[cls] == '0) return 24'(MIN_WEIGHT);
    return 24'(shadow_weight[cls]);
  endfunction

  function automatic logic [TIME_W-1:0] stretch(logic [TIME_W-1:0] now,
      logic [TIME_W-1:0] t, logic [23:0] num, logic [23:0] den);
    logic [79:0] prod;
    logic [TIME_W-1:0] mag;
    logic [TIME_W:0] sum;
    prod = ({32'b0, (t >= now) ? t - now : now - t} * {56'b0, num}) / {56'b0, den};
    mag = (prod > {32'b0, TIME_MAX}) ? TIME_MAX : prod[TIME_W-1:0];
    if (t >= now) begin
      sum = {1'b0, now} + {1'b0, mag};
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    end
    return (mag > now) ? '0 : now - mag;
  endfunction

  function automatic result_t serve_job(job_t j);
    result_t r;
    int n, pick;
    logic [23:0] w_old, w_job, w_new;
    logic [OCC_W-1:0] cap;
    r = '0;
    n = 0;
    w_old = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_busy[i]) begin
        n++;
        w_old += share_of(slot_cls[i]);
      end
    end
    cap = (shadow_cap < SLOTS) ? shadow_cap : OCC_W'(SLOTS);
    r.occupancy = OCC_W'(n);
    if (j.operation == OP_ARRIVE) begin
      r.out_tag = j.job_tag;
      r.out_class = j.job_class;
      if (n >= int'(cap)) return r;
      pick = -1;
      for (int i = SLOTS - 1; i >= 0; i--) if (!slot_busy[i]) pick = i;
      w_job = share_of(j.job_class);
      w_new = w_old + w_job;
      if (w_old != 0)
        for (int i = 0; i < SLOTS; i++)
          if (slot_busy[i]) slot_fin[i] = stretch(j.now_time, slot_fin[i], w_new, w_old);
      slot_busy[pick] = 1'b1;
      slot_cls[pick] = j.job_class;
      slot_id[pick] = j.job_tag;
      slot_fin[pick] = stretch(j.now_time, j.alone_finish, w_new, w_job);
      r.accepted = 1'b1;
      r.out_finish = slot_fin[pick];
      r.occupancy = OCC_W'(n + 1);
      return r;
    end
    if (n == 0) return r;
    pick = -1;
    for (int i = 0; i < SLOTS; i++)
      if (slot_busy[i] && (pick < 0 || slot_fin[i] < slot_fin[pick])) pick = i;
    w_job = share_of(slot_cls[pick]);
    w_new = w_old - w_job;
    r.accepted = 1'b1;
    r.out_tag = slot_id[pick];
    r.out_class = slot_cls[pick];
    r.out_finish = slot_fin[pick];
    slot_busy[pick] = 1'b0;
    if (n > 1 && w_new != 0)
      for (int i = 0; i < SLOTS; i++)
        if (slot_busy[i]) slot_fin[i] = stretch(j.now_time, slot_fin[i], w_new, w_old);
    r.occupancy = OCC_W'(n - 1);
    return r;
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom} & {16'h0, 32'hFFFF_FFFF} |
                   (TIME_W'($urandom) << 32));
  endfunction

  function automatic job_t make_job(logic op, logic [TIME_W-1:0] now, logic [CLASS_W-1:0] cls,
      logic [TAG_W-1:0] tag, logic [TIME_W-1:0] alone);
    job_t j;
    j.operation = op;
    j.now_time = now;
    j.job_class = cls;
    j.job_tag = tag;
    j.alone_finish = alone;
    return j;
  endfunction

  task automatic queue_random(int count);
    logic [TIME_W-1:0] alone;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 85) begin
        if ($urandom_range(0, 49) == 0) sim_now = rand_time() >> $urandom_range(1, 16);
        sim_now += TIME_W'($urandom_range(0, 4000));
        alone = sim_now + TIME_W'($urandom_range(1, 1 << 20));
        pending_jobs.push_back(make_job($urandom_range(0, 99) < 45 ? OP_DEPART : OP_ARRIVE,
          sim_now, CLASS_W'($urandom), TAG_W'($urandom), alone));
      end else begin
        pending_jobs.push_back(make_job(1'($urandom), rand_time(), CLASS_W'($urandom),
          TAG_W'($urandom), rand_time()));
      end
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx <= REG_WEIGHT3) shadow_weight[idx] = val;
    else if (idx == REG_CAPACITY) shadow_cap = val[OCC_W-1:0];
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_jobs.size() != 0 || expected_results.size() != 0 || start || busy);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      job <= '0;
      gap_left <= 0;
    end else begin
      if (start && !busy) expected_results.push_back(serve_job(job));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          start <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_jobs.size() != 0 && !quiet && $urandom_range(0, 3) == 0) begin
          start <= 1'b0;
          gap_left <= $urandom_range(0, 8);
        end else if (pending_jobs.size() != 0) begin
          start <= 1'b1;
          job <= pending_jobs.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction: %p", result);
      end else begin
        want = expected_results.pop_front();
        if (result.accepted !== want.accepted || result.out_tag !== want.out_tag ||
            result.out_class !== want.out_class || result.out_finish !== want.out_finish ||
            result.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10) $display("expected %p, got %p", want, result);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    job = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    quiet = 1'b0;
    sim_now = '0;
    for (int i = 0; i < NUM_WREG; i++) shadow_weight[i] = ONE_WEIGHT;
    shadow_cap = CAP_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_fin[i] = '0;
      slot_cls[i] = '0;
      slot_id[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    pending_jobs.push_back(make_job(OP_DEPART, 48'd0, 2'd3, 8'hFF, TIME_MAX));
    pending_jobs.push_back(make_job(OP_ARRIVE, 48'd0, 2'd0, 8'h00, 48'd0));
    pending_jobs.push_back(make_job(OP_ARRIVE, 48'd0, 2'd3, 8'hFF, 48'd0));
    pending_jobs.push_back(make_job(OP_ARRIVE, 48'd100000, 2'd1, 8'h5A, 48'd500));
    pending_jobs.push_back(make_job(OP_ARRIVE, TIME_MAX, 2'd2, 8'hA5, TIME_MAX));
    pending_jobs.push_back(make_job(OP_ARRIVE, 48'd0, 2'd1, 8'h0F, TIME_MAX));
    pending_jobs.push_back(make_job(OP_ARRIVE, 48'h8000_0000_0000, 2'd2, 8'hF0, 48'd1));
    for (int i = 0; i < 7; i++)
      pending_jobs.push_back(make_job(OP_DEPART, 48'd200000, 2'd0, 8'h00, 48'd0));
    queue_random(110);
    drain();

    write_reg(REG_WEIGHT0, 16'd256);
    write_reg(REG_WEIGHT1, 16'd512);
    write_reg(REG_WEIGHT2, 16'hFFFF);
    write_reg(REG_WEIGHT3, 16'd1);
    write_reg(REG_CAPACITY, 16'd16);
    @(posedge clk) cfg_we <= 1'b0;
    queue_random(115);
    drain();

    write_reg(REG_WEIGHT0, 16'hFFFF);
    write_reg(REG_WEIGHT1, 16'd1);
    write_reg(REG_WEIGHT2, 16'h8000);
    write_reg(REG_WEIGHT3, 16'd0);
    write_reg(REG_CAPACITY, 16'd1);
    @(posedge clk) cfg_we <= 1'b0;
    queue_random(100);
    drain();

    write_reg(REG_WEIGHT0, 16'h5555);
    write_reg(REG_WEIGHT1, 16'hAAAA);
    write_reg(REG_WEIGHT2, 16'h7FFF);
    write_reg(REG_WEIGHT3, 16'hFFFF);
    write_reg(REG_CAPACITY, 16'd0);
    write_reg(3'd5, 16'hFFFF);
    write_reg(3'd6, 16'hAAAA);
    write_reg(3'd7, 16'h5555);
    @(posedge clk) cfg_we <= 1'b0;
    queue_random(60);
    drain();

    write_reg(REG_WEIGHT0, 16'd1);
    write_reg(REG_WEIGHT1, 16'd1);
    write_reg(REG_WEIGHT2, 16'd1);
    write_reg(REG_WEIGHT3, 16'd1);
    write_reg(REG_CAPACITY, 16'h001F);
    @(posedge clk) cfg_we <= 1'b0;
    queue_random(110);
    drain();

    write_reg(REG_WEIGHT0, 16'd256);
    write_reg(REG_WEIGHT1, 16'd300);
    write_reg(REG_WEIGHT2, 16'd1000);
    write_reg(REG_WEIGHT3, 16'd256);
    write_reg(REG_CAPACITY, 16'd3);
    @(posedge clk) cfg_we <= 1'b0;
    queue_random(20);
    drain();
    quiet = 1'b1;
    queue_random(170);
    drain();

    repeat (1200) @(posedge clk);
    mismatches += expected_results.size();
    if (mismatches == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
